### design/civ_pkg.sv
// ----------------------------------------------------------------------------
// civ_pkg
// Shared types, codes and defaults of the coupled idle-state voter.
// ----------------------------------------------------------------------------
package civ_pkg;

  localparam int NumClusters    = 2;
  localparam int CpusPerCluster = 4;
  localparam int NumStates      = 16;

  // internal state numbers span 0 .. NUM_STATES (at most 32)
  localparam int StW      = 6;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 4;

  localparam logic [3:0] L2FlushRst = 4'd15;

  typedef enum logic [1:0] {
    FN_SUSPEND    = 2'd0,
    FN_HOTPLUG    = 2'd1,
    FN_POWER_UP   = 2'd2,
    FN_POWERED_UP = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ABORTED   = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_BAD_COUNT = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLUSTER_DOWN = 3'd0,
    REG_CPU_DOWN     = 3'd1,
    REG_WAKEUP       = 3'd2,
    REG_L2_FLUSH     = 3'd3,
    REG_HOTPLUG      = 3'd4,
    REG_UP_ONLY      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] func;
    logic       cluster_index;
    logic [1:0] cpu_index;
    logic [3:0] requested_state;
    logic [4:0] qos_limit;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       cl_power_off;
    logic [4:0] hw_state;
    logic [4:0] reported_state;
    logic       wake_save;
    logic       wake_restore;
    logic       enter_power_down;
    logic       flush_l2;
    logic       issue_power_on;
  } res_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

### design/civ_if.sv
// ----------------------------------------------------------------------------
// civ channel interfaces
// Valid/ready channels for event words, result words and register writes.
// ----------------------------------------------------------------------------
interface civ_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       cluster_index;
  logic [1:0] cpu_index;
  logic [3:0] requested_state;
  logic [4:0] qos_limit;

  modport source (output valid, func, cluster_index, cpu_index, requested_state, qos_limit,
                  input ready);
  modport sink   (input valid, func, cluster_index, cpu_index, requested_state, qos_limit,
                  output ready);
endinterface

interface civ_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       cl_power_off;
  logic [4:0] hw_state;
  logic [4:0] reported_state;
  logic       wake_save;
  logic       wake_restore;
  logic       enter_power_down;
  logic       flush_l2;
  logic       issue_power_on;

  modport source (output valid, status, cl_power_off, hw_state, reported_state, wake_save,
                  wake_restore, enter_power_down, flush_l2, issue_power_on,
                  input ready);
  modport sink   (input valid, status, cl_power_off, hw_state, reported_state, wake_save,
                  wake_restore, enter_power_down, flush_l2, issue_power_on,
                  output ready);
endinterface

interface civ_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [civ_pkg::CfgIdxW-1:0]  reg_index;
  logic [civ_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### design/civ_ctrl.sv
// ----------------------------------------------------------------------------
// civ_ctrl
// Sequencer: takes one event word, evaluates it, holds the result word.
// ----------------------------------------------------------------------------
module civ_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output civ_pkg::cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free      = !out_valid_q || out_ready_i;
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.commit  = (state_q == S_EVAL) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EVAL;
          if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
        end
        S_EVAL: begin
          if (out_free) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### design/civ_datapath.sv
// ----------------------------------------------------------------------------
// civ_datapath
// Vote and use-count store, register file, common-state evaluation, result.
// ----------------------------------------------------------------------------
module civ_datapath #(
  parameter int NUM_CLUSTERS     = civ_pkg::NumClusters,
  parameter int CPUS_PER_CLUSTER = civ_pkg::CpusPerCluster,
  parameter int NUM_STATES       = civ_pkg::NumStates
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  civ_pkg::cmd_t                cmd_i,
  input  civ_pkg::in_word_t            in_word_i,
  input  logic                         cfg_we_i,
  input  logic [civ_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [civ_pkg::CfgDataW-1:0] cfg_data_i,
  output civ_pkg::res_t                res_o
);

  localparam int StW     = civ_pkg::StW;
  localparam int ClIdxW  = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int CpuIdxW = (CPUS_PER_CLUSTER > 1) ? $clog2(CPUS_PER_CLUSTER) : 1;
  localparam logic [StW-1:0] MaxVote = StW'(NUM_STATES - 1);
  localparam logic [StW-1:0] AllSt   = StW'(NUM_STATES);

  function automatic logic [NUM_STATES-1:0] thermo(input logic [StW-1:0] v);
    logic [NUM_STATES-1:0] b;
    for (int i = 0; i < NUM_STATES; i++) begin
      b[i] = (StW'(i) < v);
    end
    return b;
  endfunction

  function automatic logic [StW-1:0] first_zero(input logic [NUM_STATES-1:0] b);
    logic [StW-1:0] r;
    r = AllSt;
    for (int i = NUM_STATES - 1; i >= 0; i--) begin
      if (!b[i]) r = StW'(i);
    end
    return r;
  endfunction

  // register file
  logic [3:0] cl_down_q, cpu_down_q, wake_q, l2_q, hp_q;
  logic       up_only_q;

  // per-cpu state
  logic [NUM_STATES-1:0] vote_q [NUM_CLUSTERS][CPUS_PER_CLUSTER];
  logic [1:0]            cnt_q  [NUM_CLUSTERS][CPUS_PER_CLUSTER];

  civ_pkg::in_word_t item_q;
  civ_pkg::res_t     res_q, res_d;

  logic                  idx_ok, is_down, off, cap_on, wk;
  logic [ClIdxW-1:0]     cl;
  logic [CpuIdxW-1:0]    cpu;
  logic [3:0]            raw_vote;
  logic [StW-1:0]        vote, common, own, cap, hw, sw;
  logic [NUM_STATES-1:0] new_bmp, acc;
  logic [NUM_STATES-1:0] row_eff [CPUS_PER_CLUSTER];
  logic [1:0]            own_cnt, cnt_new;
  logic                  cnt_we, vote_we;
  logic [NUM_STATES-1:0] vote_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_down_q  <= '0;
      cpu_down_q <= '0;
      wake_q     <= '0;
      l2_q       <= civ_pkg::L2FlushRst;
      hp_q       <= '0;
      up_only_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (civ_pkg::cfg_reg_e'(cfg_index_i))
        civ_pkg::REG_CLUSTER_DOWN: cl_down_q  <= cfg_data_i;
        civ_pkg::REG_CPU_DOWN:     cpu_down_q <= cfg_data_i;
        civ_pkg::REG_WAKEUP:       wake_q     <= cfg_data_i;
        civ_pkg::REG_L2_FLUSH:     l2_q       <= cfg_data_i;
        civ_pkg::REG_HOTPLUG:      hp_q       <= cfg_data_i;
        civ_pkg::REG_UP_ONLY:      up_only_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_word_i;
    if (cmd_i.commit)  res_q  <= res_d;
  end

  // common state of the addressed cluster, hardware and reported states, wake flag
  always_comb begin
    idx_ok   = (int'(item_q.cluster_index) < NUM_CLUSTERS) &&
               (int'(item_q.cpu_index) < CPUS_PER_CLUSTER);
    cl       = ClIdxW'(item_q.cluster_index);
    cpu      = CpuIdxW'(item_q.cpu_index);
    is_down  = (item_q.func == civ_pkg::FN_SUSPEND) || (item_q.func == civ_pkg::FN_HOTPLUG);
    raw_vote = (item_q.func == civ_pkg::FN_SUSPEND) ? item_q.requested_state : hp_q;
    vote     = (StW'(raw_vote) > MaxVote) ? MaxVote : StW'(raw_vote);
    new_bmp  = thermo(vote);
    own_cnt  = cnt_q[cl][cpu];
    acc      = '1;
    for (int i = 0; i < CPUS_PER_CLUSTER; i++) begin
      row_eff[i] = (is_down && (CpuIdxW'(i) == cpu)) ? new_bmp : vote_q[cl][i];
      acc        = acc & row_eff[i];
    end
    common = first_zero(acc);
    own    = first_zero(row_eff[cpu]);
    cap_on = (item_q.qos_limit != 5'd0);
    cap    = StW'(item_q.qos_limit) - StW'(1);
    off    = (common >= StW'(cl_down_q));
    if (off) begin
      hw = (cap_on && (common > cap)) ? cap : common;
      sw = hw;
    end else begin
      hw = (own > StW'(cl_down_q)) ? StW'(cl_down_q) : own;
      sw = StW'(cpu_down_q);
    end
    wk = (hw >= StW'(wake_q)) && (hw < StW'(l2_q));
  end

  // event decode
  always_comb begin
    res_d    = '0;
    cnt_we   = 1'b0;
    cnt_new  = own_cnt;
    vote_we  = 1'b0;
    vote_new = new_bmp;
    if (!idx_ok) begin
      res_d.status = civ_pkg::ST_BAD_INDEX;
    end else begin
      unique case (civ_pkg::func_e'(item_q.func))
        civ_pkg::FN_SUSPEND, civ_pkg::FN_HOTPLUG: begin
          if (own_cnt == 2'd1) begin
            cnt_we                 = 1'b1;
            cnt_new                = 2'd0;
            vote_we                = 1'b1;
            res_d.cl_power_off     = off;
            res_d.hw_state         = 5'(hw);
            res_d.reported_state   = 5'(sw);
            res_d.wake_save        = wk;
            res_d.enter_power_down = 1'b1;
            res_d.flush_l2         = off && (vote >= StW'(l2_q));
          end else if (own_cnt == 2'd2) begin
            cnt_we       = 1'b1;
            cnt_new      = 2'd1;
            res_d.status = civ_pkg::ST_ABORTED;
          end else begin
            res_d.status = civ_pkg::ST_BAD_COUNT;
          end
        end
        civ_pkg::FN_POWER_UP: begin
          if (own_cnt == 2'd0) begin
            cnt_we               = 1'b1;
            cnt_new              = 2'd1;
            res_d.issue_power_on = !up_only_q;
          end else if (own_cnt == 2'd1) begin
            cnt_we  = 1'b1;
            cnt_new = 2'd2;
          end else begin
            res_d.status = civ_pkg::ST_BAD_COUNT;
          end
        end
        civ_pkg::FN_POWERED_UP: begin
          res_d.cl_power_off = off;
          res_d.hw_state     = 5'(hw);
          res_d.wake_restore = wk;
          cnt_we             = (own_cnt == 2'd0);
          cnt_new            = 2'd1;
          vote_we            = 1'b1;
          vote_new           = '0;
        end
        default: res_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLUSTERS; c++) begin
        for (int p = 0; p < CPUS_PER_CLUSTER; p++) begin
          vote_q[c][p] <= '0;
          cnt_q[c][p]  <= (c == 0 && p == 0) ? 2'd1 : 2'd0;
        end
      end
    end else if (cmd_i.commit) begin
      if (cnt_we)  cnt_q[cl][cpu]  <= cnt_new;
      if (vote_we) vote_q[cl][cpu] <= vote_new;
    end
  end

  assign res_o = res_q;

endmodule

### design/coupled_idle_state_voter_top.sv
// ----------------------------------------------------------------------------
// coupled_idle_state_voter_top
// Per-cpu use counts and low-power votes with cluster-wide state decision.
// ----------------------------------------------------------------------------
// in_i carries one event word (suspend, hotplug down, power-up request,
// powered-up) for one cpu; out_o returns exactly one result word per event,
// in order. cfg_i writes the six setup registers, always ready; write them
// only while no event is in flight.
// An event is captured at acceptance; the evaluate state then works out the
// cluster vote and updates the count and vote store. The result word is
// registered when evaluation commits; a new event is accepted only after
// the capture/evaluate sequencer returns to idle.
// A finished result waits in the output register; while it waits the next
// event can still be captured, and its evaluation holds until out_o is
// taken. After reset all votes are cleared, every use count is 0 except
// cluster 0 cpu 0 which starts at 1, and the registers hold their defaults.
// ----------------------------------------------------------------------------
module coupled_idle_state_voter_top #(
  parameter int NUM_CLUSTERS     = civ_pkg::NumClusters,
  parameter int CPUS_PER_CLUSTER = civ_pkg::CpusPerCluster,
  parameter int NUM_STATES       = civ_pkg::NumStates
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  civ_in_if.sink       in_i,
  civ_out_if.source    out_o,
  civ_cfg_if.sink      cfg_i
);

  civ_pkg::cmd_t     cmd;
  civ_pkg::in_word_t in_word;
  civ_pkg::res_t     res;
  logic              out_valid;
  logic              in_ready;

  assign in_word.func            = in_i.func;
  assign in_word.cluster_index   = in_i.cluster_index;
  assign in_word.cpu_index       = in_i.cpu_index;
  assign in_word.requested_state = in_i.requested_state;
  assign in_word.qos_limit       = in_i.qos_limit;
  assign in_i.ready              = in_ready;
  assign cfg_i.ready             = 1'b1;

  civ_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  civ_datapath #(
    .NUM_CLUSTERS     (NUM_CLUSTERS),
    .CPUS_PER_CLUSTER (CPUS_PER_CLUSTER),
    .NUM_STATES       (NUM_STATES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.reg_index),
    .cfg_data_i  (cfg_i.wdata),
    .res_o       (res)
  );

  assign out_o.valid            = out_valid;
  assign out_o.status           = res.status;
  assign out_o.cl_power_off     = res.cl_power_off;
  assign out_o.hw_state         = res.hw_state;
  assign out_o.reported_state   = res.reported_state;
  assign out_o.wake_save        = res.wake_save;
  assign out_o.wake_restore     = res.wake_restore;
  assign out_o.enter_power_down = res.enter_power_down;
  assign out_o.flush_l2         = res.flush_l2;
  assign out_o.issue_power_on   = res.issue_power_on;

endmodule

### design/civ_checker.sv
// ----------------------------------------------------------------------------
// civ_checker
// Port-level checks of the voter, bound to the top level.
// ----------------------------------------------------------------------------
module civ_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic       cl_power_off,
  input logic [4:0] hw_state,
  input logic       enter_power_down,
  input logic       flush_l2,
  input logic       issue_power_on
);

  // a word that is waiting stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // one event at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second event taken while one is in flight");

  a_bad_index_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status == civ_pkg::ST_BAD_INDEX) |->
      !cl_power_off && (hw_state == 5'd0) && !enter_power_down && !issue_power_on)
    else $error("invalid index word carries data");

  a_flush_needs_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && flush_l2 |-> cl_power_off && enter_power_down)
    else $error("l2 flush without cluster off");

  a_down_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && enter_power_down |-> (status == civ_pkg::ST_OK) && !issue_power_on)
    else $error("power down with bad status or power-on");

endmodule

bind coupled_idle_state_voter_top civ_checker u_civ_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid         (in_i.valid),
  .in_ready         (in_i.ready),
  .out_valid        (out_o.valid),
  .out_ready        (out_o.ready),
  .status           (out_o.status),
  .cl_power_off     (out_o.cl_power_off),
  .hw_state         (out_o.hw_state),
  .enter_power_down (out_o.enter_power_down),
  .flush_l2         (out_o.flush_l2),
  .issue_power_on   (out_o.issue_power_on)
);

### tb/civ_voter_checker.sv
// ----------------------------------------------------------------------------
// civ_voter_checker
// Watches the event, result and register channels of the coupled idle-state
// voter, keeps its own copy of the use counts, votes and setup registers,
// works out the result word of every accepted event and compares each
// accepted result word field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module civ_voter_checker
  import civ_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  civ_in_if    ev,
  civ_out_if   res,
  civ_cfg_if   cfg,
  output int   pending_o,
  output int   errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumCpus = NumClusters * CpusPerCluster;

  logic [NumStates-1:0] vote_map [NumCpus];
  logic [1:0]           use_cnt  [NumCpus];
  logic [3:0]           cluster_down_q, cpu_down_q, wakeup_q, l2_flush_q, hotplug_q;
  logic                 up_only_q;
  res_t                 outcome_q [$];
  int                   err_cnt;

  function automatic int first_clear(input logic [NumStates-1:0] bits);
    for (int i = 0; i < NumStates; i++) begin
      if (!bits[i]) return i;
    end
    return NumStates;
  endfunction

  // deepest state shared by the cluster, capped by qos or by the cpu's own vote
  function automatic void cluster_state(input int cl, input int cpu, input logic [4:0] qos,
                                        output logic off, output logic [4:0] hw,
                                        output logic [4:0] sw);
    logic [NumStates-1:0] acc;
    int                   st;
    int                   cap;
    acc = '1;
    for (int i = 0; i < CpusPerCluster; i++) acc &= vote_map[cl*CpusPerCluster + i];
    st = first_clear(acc);
    sw = {1'b0, cpu_down_q};
    if (st >= int'(cluster_down_q)) begin
      off = 1'b1;
      cap = int'(qos) - 1;
      if (qos != 5'd0 && st > cap) st = cap;
      sw = st[4:0];
    end else begin
      off = 1'b0;
      st  = first_clear(vote_map[cl*CpusPerCluster + cpu]);
      if (st > int'(cluster_down_q)) st = int'(cluster_down_q);
    end
    hw = st[4:0];
  endfunction

  function automatic res_t vote_outcome(input in_word_t w);
    res_t       r;
    int         cl;
    int         cpu;
    int         k;
    logic [3:0] vote;
    logic       off;
    logic [4:0] hw;
    logic [4:0] sw;
    r   = '0;
    cl  = int'(w.cluster_index);
    cpu = int'(w.cpu_index);
    if (cl >= NumClusters || cpu >= CpusPerCluster) begin
      r.status = ST_BAD_INDEX;
      return r;
    end
    k = cl * CpusPerCluster + cpu;
    case (func_e'(w.func))
      FN_SUSPEND, FN_HOTPLUG: begin
        if (use_cnt[k] == 2'd1) begin
          use_cnt[k]  = 2'd0;
          vote        = (func_e'(w.func) == FN_SUSPEND) ? w.requested_state : hotplug_q;
          vote_map[k] = (NumStates'(1) << vote) - NumStates'(1);
          cluster_state(cl, cpu, w.qos_limit, off, hw, sw);
          r.cl_power_off     = off;
          r.hw_state         = hw;
          r.reported_state   = sw;
          r.wake_save        = (hw >= {1'b0, wakeup_q}) && (hw < {1'b0, l2_flush_q});
          r.enter_power_down = 1'b1;
          r.flush_l2         = off && (vote >= l2_flush_q);
        end else if (use_cnt[k] == 2'd2) begin
          use_cnt[k] = 2'd1;
          r.status   = ST_ABORTED;
        end else begin
          r.status = ST_BAD_COUNT;
        end
      end
      FN_POWER_UP: begin
        if (use_cnt[k] == 2'd0) begin
          use_cnt[k]       = 2'd1;
          r.issue_power_on = !up_only_q;
        end else if (use_cnt[k] == 2'd1) begin
          use_cnt[k] = 2'd2;
        end else begin
          r.status = ST_BAD_COUNT;
        end
      end
      default: begin
        cluster_state(cl, cpu, w.qos_limit, off, hw, sw);
        r.cl_power_off = off;
        r.hw_state     = hw;
        r.wake_restore = (hw >= {1'b0, wakeup_q}) && (hw < {1'b0, l2_flush_q});
        if (use_cnt[k] == 2'd0) use_cnt[k] = 2'd1;
        vote_map[k] = '0;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [4:0] want, input logic [4:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    in_word_t w;
    res_t     want;
    if (!rst_ni) begin
      for (int k = 0; k < NumCpus; k++) begin
        vote_map[k] = '0;
        use_cnt[k]  = 2'd0;
      end
      use_cnt[0]     = 2'd1;
      cluster_down_q = 4'd0;
      cpu_down_q     = 4'd0;
      wakeup_q       = 4'd0;
      l2_flush_q     = L2FlushRst;
      hotplug_q      = 4'd0;
      up_only_q      = 1'b0;
      outcome_q.delete();
      err_cnt        = 0;
      pending_o     <= 0;
      errors_o      <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_e'(cfg.reg_index))
          REG_CLUSTER_DOWN: cluster_down_q = cfg.wdata;
          REG_CPU_DOWN:     cpu_down_q     = cfg.wdata;
          REG_WAKEUP:       wakeup_q       = cfg.wdata;
          REG_L2_FLUSH:     l2_flush_q     = cfg.wdata;
          REG_HOTPLUG:      hotplug_q      = cfg.wdata;
          REG_UP_ONLY:      up_only_q      = cfg.wdata[0];
          default: ;
        endcase
      end
      if (ev.valid && ev.ready) begin
        w.func            = ev.func;
        w.cluster_index   = ev.cluster_index;
        w.cpu_index       = ev.cpu_index;
        w.requested_state = ev.requested_state;
        w.qos_limit       = ev.qos_limit;
        outcome_q.push_back(vote_outcome(w));
      end
      if (res.valid && res.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result word with no event outstanding");
          err_cnt++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", 5'(want.status), 5'(res.status));
          check_field("cl_power_off", 5'(want.cl_power_off), 5'(res.cl_power_off));
          check_field("hw_state", want.hw_state, res.hw_state);
          check_field("reported_state", want.reported_state, res.reported_state);
          check_field("wake_save", 5'(want.wake_save), 5'(res.wake_save));
          check_field("wake_restore", 5'(want.wake_restore), 5'(res.wake_restore));
          check_field("enter_power_down", 5'(want.enter_power_down),
                      5'(res.enter_power_down));
          check_field("flush_l2", 5'(want.flush_l2), 5'(res.flush_l2));
          check_field("issue_power_on", 5'(want.issue_power_on), 5'(res.issue_power_on));
        end
      end
      pending_o <= outcome_q.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the coupled idle-state voter with a short directed event sequence
// and then with mostly well-formed random power sequences per cpu under
// several register settings, stalling both channels at random. The checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  import civ_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int NumCpus    = NumClusters * CpusPerCluster;

  logic       clk;
  logic       rst_n;
  logic       no_stall;
  int         pending;
  int         errors;
  int         cycle_cnt = 0;
  logic [1:0] cnt_guess [NumCpus];

  civ_in_if  ev_if ();
  civ_out_if res_if ();
  civ_cfg_if cfg_if ();

  coupled_idle_state_voter_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (ev_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  civ_voter_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .ev        (ev_if),
    .res       (res_if),
    .cfg       (cfg_if),
    .pending_o (pending),
    .errors_o  (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= no_stall || ($urandom_range(0, 99) >= 16);
    end
  end

  function automatic in_word_t ev_word(input func_e f, input logic cl, input logic [1:0] cpu,
                                       input logic [3:0] req, input logic [4:0] qos);
    in_word_t w;
    w.func            = f;
    w.cluster_index   = cl;
    w.cpu_index       = cpu;
    w.requested_state = req;
    w.qos_limit       = qos;
    return w;
  endfunction

  // follows the use count so the random part can favor legal transitions
  function automatic void track_count(input in_word_t w);
    int k;
    k = int'(w.cluster_index) * CpusPerCluster + int'(w.cpu_index);
    case (func_e'(w.func))
      FN_SUSPEND, FN_HOTPLUG: begin
        if (cnt_guess[k] == 2'd1) cnt_guess[k] = 2'd0;
        else if (cnt_guess[k] == 2'd2) cnt_guess[k] = 2'd1;
      end
      FN_POWER_UP: begin
        if (cnt_guess[k] == 2'd0) cnt_guess[k] = 2'd1;
        else if (cnt_guess[k] == 2'd1) cnt_guess[k] = 2'd2;
      end
      default: begin
        if (cnt_guess[k] == 2'd0) cnt_guess[k] = 2'd1;
      end
    endcase
  endfunction

  function automatic in_word_t random_event();
    in_word_t w;
    int       k;
    int       roll;
    k    = $urandom_range(0, NumCpus - 1);
    roll = $urandom_range(0, 99);
    w.cluster_index   = 1'(k / CpusPerCluster);
    w.cpu_index       = 2'(k % CpusPerCluster);
    w.requested_state = 4'(($urandom_range(0, 1) == 1) ? $urandom_range(8, 15)
                                                       : $urandom_range(0, 15));
    roll = $urandom_range(0, 99);
    if (roll < 50) w.qos_limit = 5'd0;
    else if (roll < 90) w.qos_limit = 5'($urandom_range(1, 16));
    else w.qos_limit = 5'($urandom_range(0, 31));
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      w.func = 2'($urandom_range(0, 3));
    end else begin
      case (cnt_guess[k])
        2'd0: w.func = (roll < 58) ? FN_POWER_UP : FN_POWERED_UP;
        2'd1: begin
          if (roll < 75) w.func = FN_SUSPEND;
          else if (roll < 85) w.func = FN_HOTPLUG;
          else w.func = FN_POWER_UP;
        end
        default: begin
          if (roll < 55) w.func = FN_SUSPEND;
          else if (roll < 70) w.func = FN_HOTPLUG;
          else if (roll < 85) w.func = FN_POWERED_UP;
          else w.func = FN_POWER_UP;
        end
      endcase
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    if (!no_stall && $urandom_range(0, 99) < 16) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_if.valid           <= 1'b1;
    ev_if.func            <= w.func;
    ev_if.cluster_index   <= w.cluster_index;
    ev_if.cpu_index       <= w.cpu_index;
    ev_if.requested_state <= w.requested_state;
    ev_if.qos_limit       <= w.qos_limit;
    do @(posedge clk); while (!ev_if.ready);
    track_count(w);
  endtask

  task automatic load_regs(input logic [3:0] cd, input logic [3:0] cpud, input logic [3:0] wk,
                           input logic [3:0] l2, input logic [3:0] hp, input logic uo);
    cfg_reg_e   order [6];
    logic [3:0] vals  [6];
    order = '{REG_CLUSTER_DOWN, REG_CPU_DOWN, REG_WAKEUP, REG_L2_FLUSH, REG_HOTPLUG,
              REG_UP_ONLY};
    vals  = '{cd, cpud, wk, l2, hp, {3'b000, uo}};
    ev_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_if.valid     <= 1'b1;
      cfg_if.reg_index <= order[i];
      cfg_if.wdata     <= vals[i];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    rst_n                 <= 1'b0;
    no_stall              <= 1'b0;
    ev_if.valid           <= 1'b0;
    ev_if.func            <= FN_SUSPEND;
    ev_if.cluster_index   <= 1'b0;
    ev_if.cpu_index       <= 2'd0;
    ev_if.requested_state <= 4'd0;
    ev_if.qos_limit       <= 5'd0;
    cfg_if.valid          <= 1'b0;
    cfg_if.reg_index      <= REG_CLUSTER_DOWN;
    cfg_if.wdata          <= 4'd0;
    for (int k = 0; k < NumCpus; k++) cnt_guess[k] = 2'd0;
    cnt_guess[0] = 2'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_regs(4'd8, 4'd3, 4'd2, 4'd12, 4'd10, 1'b0);
    send_word(ev_word(FN_POWERED_UP, 1'b0, 2'd1, 4'd0, 5'd0));
    send_word(ev_word(FN_POWER_UP, 1'b0, 2'd2, 4'd0, 5'd0));
    send_word(ev_word(FN_POWER_UP, 1'b0, 2'd2, 4'd0, 5'd0));
    send_word(ev_word(FN_POWER_UP, 1'b0, 2'd2, 4'd0, 5'd0));
    send_word(ev_word(FN_SUSPEND, 1'b0, 2'd2, 4'd15, 5'd0));
    send_word(ev_word(FN_SUSPEND, 1'b0, 2'd2, 4'd15, 5'd0));
    send_word(ev_word(FN_SUSPEND, 1'b0, 2'd2, 4'd15, 5'd0));
    send_word(ev_word(FN_HOTPLUG, 1'b0, 2'd1, 4'd0, 5'd16));
    send_word(ev_word(FN_POWER_UP, 1'b0, 2'd3, 4'd0, 5'd0));
    send_word(ev_word(FN_SUSPEND, 1'b0, 2'd3, 4'd12, 5'd1));
    send_word(ev_word(FN_SUSPEND, 1'b0, 2'd0, 4'd15, 5'd16));
    send_word(ev_word(FN_POWERED_UP, 1'b0, 2'd2, 4'd0, 5'd5));
    send_word(ev_word(FN_POWERED_UP, 1'b0, 2'd0, 4'd15, 5'd31));
    send_word(ev_word(FN_POWERED_UP, 1'b1, 2'd3, 4'd0, 5'd0));
    send_word(ev_word(FN_SUSPEND, 1'b1, 2'd3, 4'd0, 5'd31));
    send_word(ev_word(FN_POWERED_UP, 1'b1, 2'd3, 4'd7, 5'd0));
    send_word(ev_word(FN_POWER_UP, 1'b1, 2'd0, 4'd0, 5'd0));
    send_word(ev_word(FN_HOTPLUG, 1'b1, 2'd0, 4'd9, 5'd1));

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       load_regs(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1);
        1:       load_regs(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0);
        default: load_regs(4'($urandom_range(0, 12)), 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      endcase
      no_stall <= (p == 2);
      repeat (175) send_word(random_event());
    end

    ev_if.valid <= 1'b0;
    no_stall    <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
